// File: design/tpsc_pkg.sv
package tpsc_pkg;

    // Field and datapath widths
    localparam int COORD_W = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int NORM_W  = 2 * COORD_W + 3;
    localparam int MUL_W   = COORD_W + 3;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int LO_W    = MUL_W - 1;
    localparam int HI_W    = NORM_W - LO_W;
    localparam int ACC_W   = COORD_W + NORM_W + 1;
    localparam int MAG_W   = ACC_W - 1;
    localparam int RES_W   = ACC_W + 1;
    localparam int OUT_W   = 32;
    localparam int STEP_W  = $clog2(MAG_W + 1);

    typedef logic [1:0]                mode_t;
    typedef logic [1:0]                slot_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [NORM_W-1:0]  norm_t;
    typedef logic signed [MUL_W-1:0]   mul_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic signed [RES_W-1:0]   res_t;
    typedef logic signed [OUT_W-1:0]   zout_t;
    typedef logic [STEP_W-1:0]         step_t;

    // Item modes
    localparam mode_t MODE_LOAD = 2'd0;
    localparam mode_t MODE_FWD  = 2'd1;
    localparam mode_t MODE_INV  = 2'd2;
    localparam mode_t MODE_PASS = 2'd3;

    localparam slot_t SLOT_NONE = 2'd3;

    // Multiplier operand pairs
    typedef logic [3:0] msel_t;
    localparam msel_t MSEL_NONE    = 4'd0;
    localparam msel_t MSEL_V1Y_V2Z = 4'd1;
    localparam msel_t MSEL_V1Z_V2Y = 4'd2;
    localparam msel_t MSEL_V1Z_V2X = 4'd3;
    localparam msel_t MSEL_V1X_V2Z = 4'd4;
    localparam msel_t MSEL_V1X_V2Y = 4'd5;
    localparam msel_t MSEL_V1Y_V2X = 4'd6;
    localparam msel_t MSEL_X_NXL   = 4'd7;
    localparam msel_t MSEL_X_NXH   = 4'd8;
    localparam msel_t MSEL_Y_NYL   = 4'd9;
    localparam msel_t MSEL_Y_NYH   = 4'd10;

    // Accumulator operations
    typedef logic [1:0] aop_t;
    localparam aop_t AOP_HOLD = 2'd0;
    localparam aop_t AOP_LOAD = 2'd1;
    localparam aop_t AOP_ADD  = 2'd2;
    localparam aop_t AOP_SUB  = 2'd3;

    typedef struct packed {
        logic  capture;
        msel_t msel;
        aop_t  aop;
        logic  acc_shift;
        logic  save_nx;
        logic  save_ny;
        logic  commit;
        logic  div_init;
        logic  div_step;
        logic  finish;
    } cmd_t;

endpackage

// File: design/tpsc_in_if.sv
interface tpsc_in_if;
    logic              valid;
    logic              ready;
    tpsc_pkg::mode_t   mode;
    tpsc_pkg::slot_t   probe_slot;
    tpsc_pkg::coord_t  coord_x;
    tpsc_pkg::coord_t  coord_y;
    tpsc_pkg::coord_t  coord_z;

    modport source (
        output valid, mode, probe_slot, coord_x, coord_y, coord_z,
        input  ready
    );
    modport sink (
        input  valid, mode, probe_slot, coord_x, coord_y, coord_z,
        output ready
    );
endinterface

// File: design/tpsc_out_if.sv
interface tpsc_out_if;
    logic             valid;
    logic             ready;
    tpsc_pkg::zout_t  adjusted_z;
    logic             plane_valid;
    logic             clipped;

    modport source (
        output valid, adjusted_z, plane_valid, clipped,
        input  ready
    );
    modport sink (
        input  valid, adjusted_z, plane_valid, clipped,
        output ready
    );
endinterface

// File: design/tpsc_datapath.sv
module tpsc_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  tpsc_pkg::cmd_t    cmd,
    input  tpsc_pkg::mode_t   mode,
    input  tpsc_pkg::slot_t   probe_slot,
    input  tpsc_pkg::coord_t  coord_x,
    input  tpsc_pkg::coord_t  coord_y,
    input  tpsc_pkg::coord_t  coord_z,
    output tpsc_pkg::zout_t   adjusted_z,
    output logic              plane_valid,
    output logic              clipped
);
    import tpsc_pkg::*;

    // Item registers
    mode_t  mode_reg;
    coord_t x_reg;
    coord_t y_reg;
    coord_t z_reg;

    // Plane state
    coord_t px_reg [3];
    coord_t py_reg [3];
    coord_t pz_reg [3];
    norm_t  nx_reg;
    norm_t  ny_reg;
    norm_t  nz_reg;
    logic   valid_reg;
    norm_t  tmp_x_reg;
    norm_t  tmp_y_reg;

    // Arithmetic registers
    prod_t             prod_reg;
    acc_t              acc_reg;
    acc_t              acc_next;
    logic [MAG_W-1:0]  num_reg;
    logic [NORM_W-1:0] rem_reg;
    logic [NORM_W-1:0] den_reg;
    logic              neg_reg;
    logic              dz_reg;

    // Output registers
    zout_t out_z_reg;
    logic  out_pv_reg;
    logic  out_clip_reg;

    diff_t v1x, v1y, v1z, v2x, v2y, v2z;
    mul_t  mul_a, mul_b;
    prod_t prod_c;
    acc_t  addend;
    norm_t nz_new;
    acc_t  acc_abs;
    norm_t nz_abs;
    logic [NORM_W:0] trial_shift;
    logic [NORM_W:0] trial_diff;
    logic            trial_ge;
    res_t  quo_ext;
    res_t  q_signed;
    res_t  res;
    logic [RES_W-OUT_W:0] res_top;
    logic  res_ovf;

    // Edge vectors of the probed triangle
    assign v1x = diff_t'(px_reg[1]) - diff_t'(px_reg[0]);
    assign v1y = diff_t'(py_reg[1]) - diff_t'(py_reg[0]);
    assign v1z = diff_t'(pz_reg[1]) - diff_t'(pz_reg[0]);
    assign v2x = diff_t'(px_reg[2]) - diff_t'(px_reg[0]);
    assign v2y = diff_t'(py_reg[2]) - diff_t'(py_reg[0]);
    assign v2z = diff_t'(pz_reg[2]) - diff_t'(pz_reg[0]);

    // Select multiplier operands; normals are split into low and high halves
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.msel)
            MSEL_V1Y_V2Z:
            begin
                mul_a = mul_t'(v1y);
                mul_b = mul_t'(v2z);
            end
            MSEL_V1Z_V2Y:
            begin
                mul_a = mul_t'(v1z);
                mul_b = mul_t'(v2y);
            end
            MSEL_V1Z_V2X:
            begin
                mul_a = mul_t'(v1z);
                mul_b = mul_t'(v2x);
            end
            MSEL_V1X_V2Z:
            begin
                mul_a = mul_t'(v1x);
                mul_b = mul_t'(v2z);
            end
            MSEL_V1X_V2Y:
            begin
                mul_a = mul_t'(v1x);
                mul_b = mul_t'(v2y);
            end
            MSEL_V1Y_V2X:
            begin
                mul_a = mul_t'(v1y);
                mul_b = mul_t'(v2x);
            end
            MSEL_X_NXL:
            begin
                mul_a = mul_t'(x_reg);
                mul_b = $signed({1'b0, nx_reg[LO_W-1:0]});
            end
            MSEL_X_NXH:
            begin
                mul_a = mul_t'(x_reg);
                mul_b = mul_t'($signed(nx_reg[NORM_W-1:LO_W]));
            end
            MSEL_Y_NYL:
            begin
                mul_a = mul_t'(y_reg);
                mul_b = $signed({1'b0, ny_reg[LO_W-1:0]});
            end
            MSEL_Y_NYH:
            begin
                mul_a = mul_t'(y_reg);
                mul_b = mul_t'($signed(ny_reg[NORM_W-1:LO_W]));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_c = mul_a * mul_b;

    // Accumulate the registered product, shifted for high halves
    assign addend = cmd.acc_shift ? (acc_t'(prod_reg) <<< LO_W) : acc_t'(prod_reg);

    always_comb
    begin
        case (cmd.aop)
            AOP_LOAD: acc_next = addend;
            AOP_ADD:  acc_next = acc_reg + addend;
            AOP_SUB:  acc_next = acc_reg - addend;
            default:  acc_next = acc_reg;
        endcase
    end

    assign nz_new  = norm_t'(acc_reg);
    assign acc_abs = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
    assign nz_abs  = nz_reg[NORM_W-1] ? -nz_reg : nz_reg;

    // One restoring divide step
    assign trial_shift = {rem_reg, num_reg[MAG_W-1]};
    assign trial_diff  = trial_shift - {1'b0, den_reg};
    assign trial_ge    = !trial_diff[NORM_W];

    // Final sum and saturation
    assign quo_ext  = res_t'({1'b0, num_reg});
    assign q_signed = dz_reg ? '0 : (neg_reg ? -quo_ext : quo_ext);
    assign res      = (mode_reg == MODE_FWD) ? (res_t'(z_reg) - q_signed)
                                             : (res_t'(z_reg) + q_signed);
    assign res_top  = res[RES_W-1:OUT_W-1];
    assign res_ovf  = !((&res_top) || !(|res_top));

    // Capture the item
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= mode;
            x_reg    <= coord_x;
            y_reg    <= coord_y;
            z_reg    <= coord_z;
        end
    end

    // Hold probed points and the plane normal
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                px_reg[i] <= '0;
                py_reg[i] <= '0;
                pz_reg[i] <= '0;
            end
            nx_reg    <= '0;
            ny_reg    <= '0;
            nz_reg    <= norm_t'(1);
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture && mode == MODE_LOAD && probe_slot != SLOT_NONE)
            begin
                px_reg[probe_slot] <= coord_x;
                py_reg[probe_slot] <= coord_y;
                pz_reg[probe_slot] <= coord_z;
            end
            if (cmd.commit)
            begin
                if (nz_new == '0)
                begin
                    valid_reg <= 1'b0;
                end
                else
                begin
                    valid_reg <= 1'b1;
                    if (nz_new[NORM_W-1])
                    begin
                        nx_reg <= -tmp_x_reg;
                        ny_reg <= -tmp_y_reg;
                        nz_reg <= -nz_new;
                    end
                    else
                    begin
                        nx_reg <= tmp_x_reg;
                        ny_reg <= tmp_y_reg;
                        nz_reg <= nz_new;
                    end
                end
            end
        end
    end

    // Multiply, accumulate and divide
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_c;
        acc_reg  <= acc_next;
        if (cmd.save_nx)
        begin
            tmp_x_reg <= norm_t'(acc_reg);
        end
        if (cmd.save_ny)
        begin
            tmp_y_reg <= norm_t'(acc_reg);
        end
        if (cmd.div_init)
        begin
            num_reg <= acc_abs[MAG_W-1:0];
            rem_reg <= '0;
            den_reg <= nz_abs;
            neg_reg <= acc_reg[ACC_W-1] ^ nz_reg[NORM_W-1];
            dz_reg  <= (nz_reg == '0);
        end
        else if (cmd.div_step)
        begin
            num_reg <= {num_reg[MAG_W-2:0], trial_ge};
            rem_reg <= trial_ge ? trial_diff[NORM_W-1:0] : trial_shift[NORM_W-1:0];
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_pv_reg <= valid_reg;
            if (mode_reg == MODE_FWD || mode_reg == MODE_INV)
            begin
                if (res_ovf)
                begin
                    out_z_reg    <= res[RES_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                                 : {1'b0, {(OUT_W-1){1'b1}}};
                    out_clip_reg <= 1'b1;
                end
                else
                begin
                    out_z_reg    <= res[OUT_W-1:0];
                    out_clip_reg <= 1'b0;
                end
            end
            else
            begin
                out_z_reg    <= zout_t'(z_reg);
                out_clip_reg <= 1'b0;
            end
        end
    end

    assign adjusted_z  = out_z_reg;
    assign plane_valid = out_pv_reg;
    assign clipped     = out_clip_reg;

endmodule

// File: design/tpsc_controller.sv
module tpsc_controller (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  tpsc_pkg::mode_t  item_mode,
    output logic             item_ready,
    output logic             result_valid,
    input  logic             result_ready,
    output tpsc_pkg::cmd_t   cmd
);
    import tpsc_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_SKEW = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam step_t SQ0 = step_t'(0);
    localparam step_t SQ1 = step_t'(1);
    localparam step_t SQ2 = step_t'(2);
    localparam step_t SQ3 = step_t'(3);
    localparam step_t SQ4 = step_t'(4);
    localparam step_t SQ5 = step_t'(5);
    localparam step_t SQ6 = step_t'(6);
    localparam step_t SQ7 = step_t'(7);
    localparam step_t DIV_LAST = step_t'(MAG_W - 1);

    logic [2:0] state_reg, state_next;
    step_t      step_reg, step_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !result_ready;
        cmd            = '0;
        item_ready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                step_next  = SQ0;
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    case (item_mode)
                        MODE_LOAD: state_next = ST_LOAD;
                        MODE_FWD:  state_next = ST_SKEW;
                        MODE_INV:  state_next = ST_SKEW;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            // Cross product: each product is accumulated the cycle after it is formed
            ST_LOAD:
            begin
                step_next = step_reg + step_t'(1);
                case (step_reg)
                    SQ0:
                    begin
                        cmd.msel = MSEL_V1Y_V2Z;
                    end
                    SQ1:
                    begin
                        cmd.msel = MSEL_V1Z_V2Y;
                        cmd.aop  = AOP_LOAD;
                    end
                    SQ2:
                    begin
                        cmd.msel = MSEL_V1Z_V2X;
                        cmd.aop  = AOP_SUB;
                    end
                    SQ3:
                    begin
                        cmd.save_nx = 1'b1;
                        cmd.msel    = MSEL_V1X_V2Z;
                        cmd.aop     = AOP_LOAD;
                    end
                    SQ4:
                    begin
                        cmd.msel = MSEL_V1X_V2Y;
                        cmd.aop  = AOP_SUB;
                    end
                    SQ5:
                    begin
                        cmd.save_ny = 1'b1;
                        cmd.msel    = MSEL_V1Y_V2X;
                        cmd.aop     = AOP_LOAD;
                    end
                    SQ6:
                    begin
                        cmd.aop = AOP_SUB;
                    end
                    SQ7:
                    begin
                        cmd.commit = 1'b1;
                        state_next = ST_DONE;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            // Dot product x*Nx + y*Ny from split halves of the normal
            ST_SKEW:
            begin
                step_next = step_reg + step_t'(1);
                case (step_reg)
                    SQ0:
                    begin
                        cmd.msel = MSEL_X_NXL;
                    end
                    SQ1:
                    begin
                        cmd.msel = MSEL_X_NXH;
                        cmd.aop  = AOP_LOAD;
                    end
                    SQ2:
                    begin
                        cmd.msel      = MSEL_Y_NYL;
                        cmd.aop       = AOP_ADD;
                        cmd.acc_shift = 1'b1;
                    end
                    SQ3:
                    begin
                        cmd.msel = MSEL_Y_NYH;
                        cmd.aop  = AOP_ADD;
                    end
                    SQ4:
                    begin
                        cmd.aop       = AOP_ADD;
                        cmd.acc_shift = 1'b1;
                    end
                    SQ5:
                    begin
                        cmd.div_init = 1'b1;
                        step_next    = SQ0;
                        state_next   = ST_DIV;
                    end
                    default:
                    begin
                        step_next  = SQ0;
                        state_next = ST_DIV;
                    end
                endcase
            end
            // One quotient bit per cycle
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + step_t'(1);
                if (step_reg == DIV_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            // Wait for the result register to free up
            ST_DONE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

// File: design/three_point_plane_skew_correction_top.sv
// Three-point plane skew correction.
// The item channel takes a mode, a probe slot and an x/y/z coordinate. Mode 0
// stores the point in the chosen slot and rebuilds the bed normal from the
// three held points; modes 1 and 2 move z onto or off the probed plane by
// (x*Nx + y*Ny) / Nz; mode 3 passes z through. Every beat accepted on the item
// channel gives exactly one beat on the result channel: adjusted_z,
// plane_valid and clipped.
// A probe load runs the cross-product sequence, a skew runs the dot product
// and then the divider, and a pass-through goes straight to the result
// register. One item is in work at a time and the next item is taken the cycle
// after the result is loaded. The divider is a restoring divider, which
// retires one quotient bit per cycle over the 75-bit dot product; one shared
// 27x27 multiplier forms all products.
// The result sits in an output register; a new item is accepted while it
// waits. If the receiver stalls, the next result waits in the datapath and
// the item channel stays closed until the result register is taken.
// Reset clears the probe points and the normal to the identity plane
// (normal 0,0,1) with plane_valid low; the block is ready once reset is released.
module three_point_plane_skew_correction_top (
    input logic        clk,
    input logic        rst_n,
    tpsc_in_if.sink    item,
    tpsc_out_if.source result
);
    import tpsc_pkg::*;

    cmd_t cmd;

    tpsc_controller u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_mode    (item.mode),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .cmd          (cmd)
    );

    tpsc_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .mode        (item.mode),
        .probe_slot  (item.probe_slot),
        .coord_x     (item.coord_x),
        .coord_y     (item.coord_y),
        .coord_z     (item.coord_z),
        .adjusted_z  (result.adjusted_z),
        .plane_valid (result.plane_valid),
        .clipped     (result.clipped)
    );

endmodule
